// ----- design/ils_pkg.sv -----
// Shared types and constants for the indexed list store.
// Used by the channel interfaces, the slot allocator, the top level and
// the checker.
`timescale 1ns / 1ps

package ils_pkg;

    // Field widths of the request and response words
    localparam int KIND_W = 3;
    localparam int POS_W  = 9;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 9;

    // Read value for a miss or a request that is not a read
    localparam logic [VAL_W-1:0] NOT_FOUND = '1;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_READ     = 3'd0,
        KIND_INS_HEAD = 3'd1,
        KIND_INS_TAIL = 3'd2,
        KIND_INS_POS  = 3'd3,
        KIND_DEL      = 3'd4
    } kind_t;

    // Internal operation once a request has been decoded
    typedef enum logic [2:0] {
        OP_READ,
        OP_INS_HEAD,
        OP_INS_TAIL,
        OP_INS_MID,
        OP_DEL
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_WALK,
        ST_WRITE_NEW,
        ST_WRITE_PREV,
        ST_DONE
    } state_t;

    // Commands from the sequencer to the slot allocator
    typedef struct packed {
        logic pop;
        logic push;
    } alloc_cmd_t;

endpackage

// ----- design/ils_req_if.sv -----
// Request channel: valid/ready plus kind, position and value.
// Depends on ils_pkg for the field widths.
`timescale 1ns / 1ps

interface ils_req_if;
    import ils_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, output kind, output position, output value, input ready);
    modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

// ----- design/ils_rsp_if.sv -----
// Response channel: valid/ready plus read value, accepted flag and length.
// Depends on ils_pkg for the field widths.
`timescale 1ns / 1ps

interface ils_rsp_if;
    import ils_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  read_value;
    logic                     accepted;
    logic [LEN_W-1:0]         length;

    modport source (output valid, output read_value, output accepted, output length, input ready);
    modport sink   (input valid, input read_value, input accepted, input length, output ready);
endinterface

// ----- design/ils_node_ram.sv -----
// Node RAM: one write port and one read port, read data registered.
// Each word holds a value and the slot of the next node. No dependencies.
`timescale 1ns / 1ps

module ils_node_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 40
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/ils_slot_alloc.sv -----
// Slot allocator: a stack of returned slots in RAM plus a fill count of
// fresh slots already handed out. Depends on ils_pkg for alloc_cmd_t.
`timescale 1ns / 1ps

module ils_slot_alloc #(
    parameter int CAPACITY = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ils_pkg::alloc_cmd_t           cmd,
    input  logic [$clog2(CAPACITY)-1:0]   push_slot,
    output logic [$clog2(CAPACITY)-1:0]   pop_slot
);
    import ils_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [SW-1:0] stack_mem [CAPACITY];
    logic [SW-1:0] stack_rd_reg;
    logic [SW-1:0] fresh_slot_reg;
    logic          from_stack_reg;
    logic [CW-1:0] sp_reg;
    logic [CW-1:0] sp_next;
    logic [CW-1:0] fresh_reg;
    logic [CW-1:0] fresh_next;
    logic [CW-1:0] sp_dec;
    logic          stack_empty;

    assign sp_dec      = sp_reg - CW'(1);
    assign stack_empty = (sp_reg == '0);

    // Pointer updates: pop takes a returned slot first, else a fresh one
    always_comb
    begin
        sp_next    = sp_reg;
        fresh_next = fresh_reg;
        if (cmd.pop)
        begin
            if (stack_empty)
            begin
                fresh_next = fresh_reg + CW'(1);
            end
            else
            begin
                sp_next = sp_dec;
            end
        end
        else if (cmd.push)
        begin
            sp_next = sp_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg    <= '0;
            fresh_reg <= '0;
        end
        else
        begin
            sp_reg    <= sp_next;
            fresh_reg <= fresh_next;
        end
    end

    // Stack RAM: push writes at the top, pop reads just below it
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[sp_reg[SW-1:0]] <= push_slot;
        end
        if (cmd.pop && !stack_empty)
        begin
            stack_rd_reg <= stack_mem[sp_dec[SW-1:0]];
        end
    end

    // Popped slot is valid the cycle after the pop
    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            from_stack_reg <= !stack_empty;
            fresh_slot_reg <= fresh_reg[SW-1:0];
        end
    end

    assign pop_slot = from_stack_reg ? stack_rd_reg : fresh_slot_reg;

endmodule

// ----- design/indexed_list_store.sv -----
// Indexed list store: top level with the request sequencer.
// Depends on ils_pkg, ils_req_if, ils_rsp_if, ils_node_ram, ils_slot_alloc.
//
// Usage
//   req carries one request word (kind, position, value); rsp returns one
//   word per request (read_value, accepted, length). Words move when valid
//   and ready are both high. One request is in work at a time.
//   Flow, with p the request position: a read or delete walks the links
//   from the head to node p; an insert takes a slot from the allocator,
//   a middle insert (before p) then walks to node p - 1, and every insert
//   writes the new node and, but for an insert at the head, then points
//   the predecessor (or the old tail) at it. A rejected request or an
//   unknown kind goes straight to the response. The link walk does one
//   node RAM read per cycle, so the time of a walk grows with p.
//   The response sits in an output register; req is taken again as soon as
//   the sequencer is idle, so a stalled receiver holds back only the next
//   response, and the sequencer waits in its last state until it drains.
//   Reset empties the list at once: no clearing pass, as the allocator
//   tracks never-used slots by a fill count.
`timescale 1ns / 1ps

module indexed_list_store #(
    parameter int CAPACITY = 256
) (
    input logic      clk,
    input logic      rst_n,
    ils_req_if.sink  req,
    ils_rsp_if.source rsp
);
    import ils_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = VAL_W + SW;
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [POS_W-1:0]  rem_reg, rem_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic [NW-1:0]     cur_data_reg, cur_data_next;
    logic [SW-1:0]     prev_reg, prev_next;
    logic [NW-1:0]     prev_data_reg, prev_data_next;
    logic [SW-1:0]     new_reg, new_next;
    logic [SW-1:0]     head_reg, head_next;
    logic [SW-1:0]     tail_reg, tail_next;
    logic [VAL_W-1:0]  tail_val_reg, tail_val_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [VAL_W-1:0]  res_val_reg, res_val_next;
    logic              res_ok_reg, res_ok_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [VAL_W-1:0]  rsp_val_reg, rsp_val_next;
    logic              rsp_ok_reg, rsp_ok_next;
    logic [LEN_W-1:0]  rsp_len_reg, rsp_len_next;

    logic              mem_we;
    logic [SW-1:0]     mem_waddr;
    logic [NW-1:0]     mem_wdata;
    logic              mem_re;
    logic [SW-1:0]     mem_raddr;
    logic [NW-1:0]     mem_rdata;
    alloc_cmd_t        alloc_cmd;
    logic [SW-1:0]     alloc_slot;

    logic              accept;
    logic              dec_go;
    op_t               dec_op;
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     cnt_x;
    logic              full;
    logic              pos_last;
    logic              out_free;
    logic [SW-1:0]     rd_link;
    logic [VAL_W-1:0]  rd_val;

    // Node storage and slot allocation
    ils_node_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (NW)
    ) u_node_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ils_slot_alloc #(
        .CAPACITY (CAPACITY)
    ) u_slot_alloc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (alloc_cmd),
        .push_slot (cur_reg),
        .pop_slot  (alloc_slot)
    );

    // Requests are taken only while the sequencer is idle
    assign req.ready = (state_reg == ST_IDLE);

    assign rd_link  = mem_rdata[SW-1:0];
    assign rd_val   = mem_rdata[NW-1 -: VAL_W];
    assign accept   = req.valid && req.ready;
    assign pos_x    = XW'(req.position);
    assign cnt_x    = XW'(count_reg);
    assign full     = (count_reg == CW'(CAPACITY));
    assign pos_last = (({1'b0, XW'(pos_reg)} + (XW+1)'(1)) == {1'b0, cnt_x});
    assign out_free = !rsp_valid_reg || rsp.ready;

    // Request decode against the current length
    always_comb
    begin
        dec_go = 1'b0;
        dec_op = OP_READ;
        case (kind_t'(req.kind))
            KIND_READ:
            begin
                dec_go = (pos_x < cnt_x);
                dec_op = OP_READ;
            end
            KIND_INS_HEAD:
            begin
                dec_go = !full;
                dec_op = OP_INS_HEAD;
            end
            KIND_INS_TAIL:
            begin
                dec_go = !full;
                dec_op = (count_reg == '0) ? OP_INS_HEAD : OP_INS_TAIL;
            end
            KIND_INS_POS:
            begin
                dec_go = !full && (pos_x <= cnt_x);
                if (req.position == '0)
                begin
                    dec_op = OP_INS_HEAD;
                end
                else if (pos_x == cnt_x)
                begin
                    dec_op = OP_INS_TAIL;
                end
                else
                begin
                    dec_op = OP_INS_MID;
                end
            end
            KIND_DEL:
            begin
                dec_go = (pos_x < cnt_x);
                dec_op = OP_DEL;
            end
            default:
            begin
                dec_go = 1'b0;
                dec_op = OP_READ;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (!dec_go)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (dec_op == OP_READ || dec_op == OP_DEL)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_ALLOC;
                    end
                end
            end
            ST_ALLOC:
            begin
                state_next = (op_reg == OP_INS_MID) ? ST_WALK : ST_WRITE_NEW;
            end
            ST_WALK:
            begin
                if (rem_reg == '0)
                begin
                    state_next = (op_reg == OP_INS_MID) ? ST_WRITE_NEW : ST_DONE;
                end
            end
            ST_WRITE_NEW:
            begin
                state_next = (op_reg == OP_INS_HEAD) ? ST_DONE : ST_WRITE_PREV;
            end
            ST_WRITE_PREV:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath. RAM reads and writes never share a state branch,
    // so the same entry is never read and written in one cycle.
    always_comb
    begin
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        rem_next       = rem_reg;
        cur_next       = cur_reg;
        cur_data_next  = cur_data_reg;
        prev_next      = prev_reg;
        prev_data_next = prev_data_reg;
        new_next       = new_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        tail_val_next  = tail_val_reg;
        count_next     = count_reg;
        res_val_next   = res_val_reg;
        res_ok_next    = res_ok_reg;
        rsp_val_next   = rsp_val_reg;
        rsp_ok_next    = rsp_ok_reg;
        rsp_len_next   = rsp_len_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        mem_wdata      = cur_data_reg;
        mem_re         = 1'b0;
        mem_raddr      = head_reg;
        alloc_cmd      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next      = dec_op;
                    pos_next     = req.position;
                    val_next     = req.value;
                    res_val_next = NOT_FOUND;
                    res_ok_next  = dec_go;
                    if (dec_go)
                    begin
                        if (dec_op == OP_READ || dec_op == OP_DEL)
                        begin
                            // start the walk at the head
                            mem_re    = 1'b1;
                            mem_raddr = head_reg;
                            cur_next  = head_reg;
                            rem_next  = req.position;
                        end
                        else
                        begin
                            alloc_cmd.pop = 1'b1;
                        end
                    end
                end
            end
            ST_ALLOC:
            begin
                new_next = alloc_slot;
                if (op_reg == OP_INS_MID)
                begin
                    // walk to the node before the insert point
                    mem_re    = 1'b1;
                    mem_raddr = head_reg;
                    cur_next  = head_reg;
                    rem_next  = pos_reg - POS_W'(1);
                end
            end
            ST_WALK:
            begin
                if (rem_reg != '0)
                begin
                    // follow one link
                    mem_re         = 1'b1;
                    mem_raddr      = rd_link;
                    cur_next       = rd_link;
                    prev_next      = cur_reg;
                    prev_data_next = mem_rdata;
                    rem_next       = rem_reg - POS_W'(1);
                end
                else
                begin
                    cur_data_next = mem_rdata;
                    case (op_reg)
                        OP_READ:
                        begin
                            res_val_next = rd_val;
                        end
                        OP_DEL:
                        begin
                            // unlink the node and return its slot
                            alloc_cmd.push = 1'b1;
                            count_next     = count_reg - CW'(1);
                            if (pos_reg == '0)
                            begin
                                head_next = rd_link;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = prev_reg;
                                mem_wdata = {prev_data_reg[NW-1 -: VAL_W], rd_link};
                                if (pos_last)
                                begin
                                    tail_next     = prev_reg;
                                    tail_val_next = prev_data_reg[NW-1 -: VAL_W];
                                end
                            end
                        end
                        default:
                        begin
                            res_val_next = res_val_reg;
                        end
                    endcase
                end
            end
            ST_WRITE_NEW:
            begin
                mem_we    = 1'b1;
                mem_waddr = new_reg;
                case (op_reg)
                    OP_INS_HEAD:
                    begin
                        mem_wdata  = {val_reg, head_reg};
                        head_next  = new_reg;
                        count_next = count_reg + CW'(1);
                        if (count_reg == '0)
                        begin
                            tail_next     = new_reg;
                            tail_val_next = val_reg;
                        end
                    end
                    OP_INS_TAIL:
                    begin
                        mem_wdata = {val_reg, SW'(0)};
                    end
                    default:
                    begin
                        mem_wdata = {val_reg, cur_data_reg[SW-1:0]};
                    end
                endcase
            end
            ST_WRITE_PREV:
            begin
                // point the predecessor at the new node
                mem_we     = 1'b1;
                count_next = count_reg + CW'(1);
                if (op_reg == OP_INS_TAIL)
                begin
                    mem_waddr     = tail_reg;
                    mem_wdata     = {tail_val_reg, new_reg};
                    tail_next     = new_reg;
                    tail_val_next = val_reg;
                end
                else
                begin
                    mem_waddr = cur_reg;
                    mem_wdata = {cur_data_reg[NW-1 -: VAL_W], new_reg};
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_val_next   = res_val_reg;
                    rsp_ok_next    = res_ok_reg;
                    rsp_len_next   = LEN_W'(count_reg);
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        rem_reg       <= rem_next;
        cur_reg       <= cur_next;
        cur_data_reg  <= cur_data_next;
        prev_reg      <= prev_next;
        prev_data_reg <= prev_data_next;
        new_reg       <= new_next;
        tail_val_reg  <= tail_val_next;
        res_val_reg   <= res_val_next;
        res_ok_reg    <= res_ok_next;
        rsp_val_reg   <= rsp_val_next;
        rsp_ok_reg    <= rsp_ok_next;
        rsp_len_reg   <= rsp_len_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = rsp_val_reg;
    assign rsp.accepted   = rsp_ok_reg;
    assign rsp.length     = rsp_len_reg;

endmodule

// ----- design/ils_checker.sv -----
// Port-level checks for indexed_list_store, bound to the top level.
// Depends on ils_pkg for widths and the miss value.
`timescale 1ns / 1ps

module ils_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [ils_pkg::VAL_W-1:0]  rsp_read_value,
    input logic                       rsp_accepted,
    input logic [ils_pkg::LEN_W-1:0]  rsp_length
);
    import ils_pkg::*;

    logic [1:0]       pending_reg;
    logic [LEN_W-1:0] last_len_reg;
    logic             req_fire;
    logic             rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // Requests taken but not yet answered, and the last length reported
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            last_len_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(req_fire) - 2'(rsp_fire);
            if (rsp_fire)
            begin
                last_len_reg <= rsp_length;
            end
        end
    end

    // A stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
            && $stable(rsp_accepted) && $stable(rsp_length))
        else $error("response word changed while stalled");

    // No response without a request behind it
    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("response without an outstanding request");

    // A rejected request reads as a miss
    a_reject_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && !rsp_accepted |-> rsp_read_value == NOT_FOUND)
        else $error("rejected request returned a value");

    // A rejected request leaves the length alone
    a_reject_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && !rsp_accepted |-> rsp_length == last_len_reg)
        else $error("rejected request changed the length");

endmodule

bind indexed_list_store ils_checker u_ils_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_read_value (rsp.read_value),
    .rsp_accepted   (rsp.accepted),
    .rsp_length     (rsp.length)
);
